### src/cluster_frame_parser_assert.svh
// Assertion macros for the frame parser. Each macro expects clk and rst_n
// to be visible where it is used.
`ifndef CLUSTER_FRAME_PARSER_ASSERT_SVH
`define CLUSTER_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

### src/cfp_pkg.sv
`timescale 1ns / 1ps

package cfp_pkg;

  localparam logic [3:0] NIB_BC  = 4'hA;
  localparam logic [3:0] NIB_EC  = 4'hC;
  localparam logic [3:0] NIB_ID  = 4'hE;
  localparam logic [3:0] NIB_HDR = 4'h8;
  localparam logic [7:0] TRL_HI  = 8'hF0;

  localparam logic KIND_CLUSTER = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR       = 5'b00001,
    PH_AFTER_HDR = 5'b00010,
    PH_AFTER_BC  = 5'b00100,
    PH_AFTER_EC  = 5'b01000,
    PH_PAYLOAD   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        record_kind;
    logic [6:0]  cluster_size;
    logic [7:0]  cluster_start;
    logic [11:0] bunch_count;
    logic [7:0]  event_count;
    logic [3:0]  ec_flags;
    logic [11:0] chip_id;
    logic [2:0]  present_mask;
    logic [11:0] header_info;
    logic [7:0]  trailer_size;
    logic        footprint_ok;
    logic        sync_ok;
  } rec_t;

endpackage

### src/cluster_frame_parser.sv
`timescale 1ns / 1ps

// Frame word parser. Each accepted 16-bit word passes an input register, one
// level of decode logic and a result register, so a new word is taken in every
// cycle while the result side does not stall; its record is presented on the
// result side once the word has passed both registers. A header, or an optional
// word in its order after the header, gives no record, a cluster word gives a
// cluster record, and the trailer gives the summary record of its frame. A stall
// on the result side holds the full result register; the input register may still
// take one more word, and the input stalls in the same cycle once both are full.
module cluster_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_raw_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [6:0]  out_cluster_size,
  output logic [7:0]  out_cluster_start,
  output logic [11:0] out_bunch_count,
  output logic [7:0]  out_event_count,
  output logic [3:0]  out_ec_flags,
  output logic [11:0] out_chip_id,
  output logic [2:0]  out_present_mask,
  output logic [11:0] out_header_info,
  output logic [7:0]  out_trailer_size,
  output logic        out_footprint_ok,
  output logic        out_sync_ok
);
  import cfp_pkg::*;

  logic        adv;
  logic        s1_vld;
  logic [15:0] s1_word;
  logic        fire;
  logic        emit;
  rec_t        rec;
  rec_t        out_rec;

  cfp_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_word (in_raw_word),
    .adv         (adv),
    .s1_vld      (s1_vld),
    .s1_word     (s1_word)
  );

  cfp_parser u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_vld  (s1_vld),
    .s1_word (s1_word),
    .adv     (adv),
    .fire    (fire),
    .emit    (emit),
    .rec     (rec)
  );

  cfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .emit      (emit),
    .rec       (rec),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign out_record_kind   = out_rec.record_kind;
  assign out_cluster_size  = out_rec.cluster_size;
  assign out_cluster_start = out_rec.cluster_start;
  assign out_bunch_count   = out_rec.bunch_count;
  assign out_event_count   = out_rec.event_count;
  assign out_ec_flags      = out_rec.ec_flags;
  assign out_chip_id       = out_rec.chip_id;
  assign out_present_mask  = out_rec.present_mask;
  assign out_header_info   = out_rec.header_info;
  assign out_trailer_size  = out_rec.trailer_size;
  assign out_footprint_ok  = out_rec.footprint_ok;
  assign out_sync_ok       = out_rec.sync_ok;

endmodule

### src/cfp_in_stage.sv
`timescale 1ns / 1ps

module cfp_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_raw_word,
  input  logic        adv,
  output logic        s1_vld,
  output logic [15:0] s1_word
);
  import cfp_pkg::*;

  logic        s1_vld_r;
  logic        s1_vld_nxt;
  logic [15:0] s1_word_r;
  logic        accept;

  assign in_stall = s1_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_raw_word;
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_word = s1_word_r;

endmodule

### src/cfp_parser.sv
`timescale 1ns / 1ps

module cfp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_vld,
  input  logic [15:0]   s1_word,
  input  logic          adv,
  output logic          fire,
  output logic          emit,
  output cfp_pkg::rec_t rec
);
  import cfp_pkg::*;

  `include "cluster_frame_parser_assert.svh"

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] hdr_r;
  logic [15:0] hdr_nxt;
  logic [11:0] bc_r;
  logic [11:0] bc_nxt;
  logic [11:0] ec_r;
  logic [11:0] ec_nxt;
  logic [11:0] id_r;
  logic [11:0] id_nxt;
  logic [2:0]  pres_r;
  logic [2:0]  pres_nxt;
  logic [3:0]  nib;
  logic [3:0]  rx;
  logic        is_bc;
  logic        is_ec;
  logic        is_id;

  assign fire = s1_vld && adv;
  assign nib  = s1_word[15:12];
  assign rx   = hdr_r[11:8];

  assign is_bc = (phase_r == PH_AFTER_HDR) && (nib == NIB_BC);
  assign is_ec = ((phase_r == PH_AFTER_HDR) || (phase_r == PH_AFTER_BC)) && (nib == NIB_EC);
  assign is_id = ((phase_r == PH_AFTER_HDR) || (phase_r == PH_AFTER_BC) ||
                  (phase_r == PH_AFTER_EC)) && (nib == NIB_ID);

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    bc_nxt    = bc_r;
    ec_nxt    = ec_r;
    id_nxt    = id_r;
    pres_nxt  = pres_r;
    emit      = 1'b0;
    rec       = '0;
    priority if (phase_r == PH_HDR) begin
      hdr_nxt   = s1_word;
      pres_nxt  = 3'b000;
      phase_nxt = PH_AFTER_HDR;
    end else if (is_bc) begin
      bc_nxt    = s1_word[11:0];
      pres_nxt  = pres_r | 3'b001;
      phase_nxt = PH_AFTER_BC;
    end else if (is_ec) begin
      ec_nxt    = s1_word[11:0];
      pres_nxt  = pres_r | 3'b010;
      phase_nxt = PH_AFTER_EC;
    end else if (is_id) begin
      id_nxt    = s1_word[11:0];
      pres_nxt  = pres_r | 3'b100;
      phase_nxt = PH_PAYLOAD;
    end else if (!s1_word[15]) begin
      emit              = 1'b1;
      rec.record_kind   = KIND_CLUSTER;
      rec.cluster_size  = s1_word[14:8];
      rec.cluster_start = s1_word[7:0];
      phase_nxt         = PH_PAYLOAD;
    end else begin
      emit              = 1'b1;
      rec.record_kind   = KIND_SUMMARY;
      rec.bunch_count   = pres_r[0] ? bc_r : 12'd0;
      rec.event_count   = pres_r[1] ? ec_r[11:4] : 8'd0;
      rec.ec_flags      = pres_r[1] ? ec_r[3:0] : 4'd0;
      rec.chip_id       = pres_r[2] ? id_r : 12'd0;
      rec.present_mask  = pres_r;
      rec.header_info   = hdr_r[11:0];
      rec.trailer_size  = s1_word[7:0];
      rec.footprint_ok  = (s1_word[15:8] == TRL_HI) && (hdr_r[15:12] == NIB_HDR);
      rec.sync_ok       = !rx[0] && (pres_r[1] || (rx[1:0] == 2'b00)) &&
                          (pres_r[0] || !rx[2]);
      phase_nxt         = PH_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pres_r  <= 3'b000;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pres_r  <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hdr_r <= hdr_nxt;
      bc_r  <= bc_nxt;
      ec_r  <= ec_nxt;
      id_r  <= id_nxt;
    end
  end

  `CFP_ASSERT_SAME(a_hdr_silent, fire && (phase_r == PH_HDR), !emit)
  `CFP_ASSERT_NEXT(a_hdr_clears, fire && (phase_r == PH_HDR),
                   (pres_r == 3'b000) && (phase_r == PH_AFTER_HDR))
  `CFP_ASSERT_NEXT(a_trailer_rearms, fire && emit && (rec.record_kind == KIND_SUMMARY),
                   phase_r == PH_HDR)
  `CFP_ASSERT_NEXT(a_cluster_payload, fire && emit && (rec.record_kind == KIND_CLUSTER),
                   phase_r == PH_PAYLOAD)

endmodule

### src/cfp_out_stage.sv
`timescale 1ns / 1ps

module cfp_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          emit,
  input  cfp_pkg::rec_t rec,
  output logic          adv,
  output logic          out_valid,
  input  logic          out_stall,
  output cfp_pkg::rec_t out_rec
);
  import cfp_pkg::*;

  logic out_vld_r;
  logic out_vld_nxt;
  rec_t rec_r;

  assign adv = !out_vld_r || !out_stall;

  always_comb begin
    if (fire) begin
      out_vld_nxt = emit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      rec_r <= rec;
    end
  end

  assign out_valid = out_vld_r;
  assign out_rec   = rec_r;

endmodule
